// ===== rtl/cts_pkg.sv =====
package cts_pkg;

    // Series magnitudes are unsigned with 8 integer and 56 fraction bits.
    localparam int unsigned IFB = 56;

    // The magnitude of the angle is shifted left by this before reduction.
    localparam int unsigned GUARD_SHIFT = 28;

    // Two pi with 60 fraction bits.
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

    typedef logic [63:0] t_word;

endpackage

// ===== rtl/cts_qmul.sv =====
module cts_qmul (
    input  logic             i_clk,
    input  logic             i_en,
    input  cts_pkg::t_word   i_a,
    input  cts_pkg::t_word   i_b,
    output cts_pkg::t_word   o_p
);

    logic [63:0]    r_ll;
    logic [63:0]    r_lh;
    logic [63:0]    r_hl;
    logic [63:0]    r_hh;
    cts_pkg::t_word r_p;
    logic [127:0]   n_full;

    // The first stage forms the four 32 by 32 partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0]  * i_b[31:0];
            r_lh <= i_a[31:0]  * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_hh <= i_a[63:32] * i_b[63:32];
        end
    end

    always_comb begin
        n_full = {r_hh, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0};
    end

    // The second stage sums them and truncates to 56 fraction bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_full[cts_pkg::IFB + 63:cts_pkg::IFB];
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/cts_mod_cell.sv =====
module cts_mod_cell #(
    parameter logic [63:0] MODULUS = 64'd1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cts_pkg::t_word   i_value,
    output logic             o_valid,
    output cts_pkg::t_word   o_value
);

    logic           r_valid;
    cts_pkg::t_word r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // One restoring step of the reduction: subtract the shifted modulus if it fits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_value >= MODULUS) begin
                r_value <= i_value - MODULUS;
            end else begin
                r_value <= i_value;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// ===== rtl/cts_term_cell.sv =====
module cts_term_cell #(
    parameter int unsigned TERM_INDEX = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cts_pkg::t_word   i_term,
    input  cts_pkg::t_word   i_sum,
    input  cts_pkg::t_word   i_x2,
    output logic             o_valid,
    output cts_pkg::t_word   o_term,
    output cts_pkg::t_word   o_sum,
    output cts_pkg::t_word   o_x2
);

    localparam logic [63:0] DEN   = 64'((2 * TERM_INDEX - 1) * (2 * TERM_INDEX));
    localparam logic [63:0] RECIP = ((64'd1 << cts_pkg::IFB) + DEN / 2) / DEN;
    localparam bit          SUBTRACT = ((TERM_INDEX - 1) % 2) == 1;
    localparam int unsigned DEPTH = 4;

    logic             r_valid [DEPTH];
    cts_pkg::t_word   r_sum   [DEPTH];
    cts_pkg::t_word   r_x2    [DEPTH];
    cts_pkg::t_word   n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int i = 1; i < DEPTH; i++) begin
                r_valid[i] <= r_valid[i - 1];
            end
        end
    end

    // The incoming term joins the sum while its successor is being formed.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (SUBTRACT) begin
                r_sum[0] <= i_sum - i_term;
            end else begin
                r_sum[0] <= i_sum + i_term;
            end
            r_x2[0] <= i_x2;
            for (int i = 1; i < DEPTH; i++) begin
                r_sum[i] <= r_sum[i - 1];
                r_x2[i]  <= r_x2[i - 1];
            end
        end
    end

    cts_qmul u_recip_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_term),
        .i_b   (RECIP),
        .o_p   (n_prod)
    );

    cts_qmul u_x2_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (n_prod),
        .i_b   (r_x2[1]),
        .o_p   (o_term)
    );

    assign o_valid = r_valid[DEPTH - 1];
    assign o_sum   = r_sum[DEPTH - 1];
    assign o_x2    = r_x2[DEPTH - 1];

endmodule

// ===== rtl/cosine_taylor_series.sv =====
// Cosine of a fixed-point angle by a Taylor series.
//
// The input channel takes one angle per request (i_valid, o_stall, i_angle),
// two's complement radians with ANGLE_FRAC_BITS fraction bits. The output
// channel returns one cosine per request (o_valid, i_stall, o_cosine), two's
// complement with RESULT_FRAC_BITS fraction bits, clamped to plus or minus one.
// Results leave in the order the angles came in.
//
// The block is a single pipeline and accepts one angle every cycle while
// o_stall is low. Its stages are one input stage, one reduction cell per
// quotient bit of the modulo two pi, two stages for the square, four stages
// for each series cell (two pipelined multiplies) and four output stages for
// the last add, the magnitude, the rounding, and the clamp with the sign.
//
// While a result is held in the output register and i_stall is high, the
// whole pipeline holds and o_stall is raised. Reset empties the pipeline;
// there is no other state.
module cosine_taylor_series #(
    parameter int unsigned SERIES_TERMS     = 18,
    parameter int unsigned ANGLE_FRAC_BITS  = 24,
    parameter int unsigned RESULT_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_cosine
);

    localparam int unsigned WF        = ANGLE_FRAC_BITS + cts_pkg::GUARD_SHIFT;
    localparam int unsigned TSH       = 60 - WF;
    localparam logic [63:0] TWO_PI_W  =
        (cts_pkg::TWO_PI_Q60 + (64'd1 << (TSH - 1))) >> TSH;
    localparam int unsigned RED_STEPS = 29 - ANGLE_FRAC_BITS;
    localparam int unsigned X_SHIFT   = cts_pkg::IFB - WF;
    localparam int unsigned CELLS     = SERIES_TERMS - 1;
    localparam bit          LAST_SUB  = (CELLS % 2) == 1;
    localparam int unsigned RSH       = cts_pkg::IFB - RESULT_FRAC_BITS;
    localparam int unsigned RND_W     = 64 - RSH;
    localparam logic [63:0] HALF      = 64'd1 << (RSH - 1);
    localparam logic [RND_W-1:0] ONE_R = RND_W'(1) << RESULT_FRAC_BITS;

    logic             n_en;
    logic             r_in_valid;
    logic [31:0]      r_in_mag;
    logic [31:0]      n_mag;

    logic             red_valid [RED_STEPS + 1];
    cts_pkg::t_word   red_value [RED_STEPS + 1];

    cts_pkg::t_word   n_x;
    cts_pkg::t_word   n_x2;
    logic             r_x2_valid [2];

    logic             cell_valid [CELLS + 1];
    cts_pkg::t_word   cell_term  [CELLS + 1];
    cts_pkg::t_word   cell_sum   [CELLS + 1];
    cts_pkg::t_word   cell_x2    [CELLS + 1];

    logic             r_f1_valid;
    cts_pkg::t_word   r_f1_sum;
    logic             r_f2_valid;
    logic             r_f2_neg;
    cts_pkg::t_word   r_f2_mag;
    logic             r_f3_valid;
    logic             r_f3_neg;
    logic [RND_W-1:0] r_f3_rnd;
    cts_pkg::t_word   n_f3_sum;
    logic [RND_W-1:0] n_clamped;
    cts_pkg::t_word   n_wide;
    logic             r_out_valid;
    logic [31:0]      r_cosine;

    assign n_en    = !(r_out_valid && i_stall);
    assign o_stall = !n_en;

    assign n_mag = i_angle[31] ? (~i_angle + 32'd1) : i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_x2_valid[0] <= 1'b0;
            r_x2_valid[1] <= 1'b0;
            r_f1_valid    <= 1'b0;
            r_f2_valid    <= 1'b0;
            r_f3_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (n_en) begin
            r_in_valid    <= i_valid;
            r_x2_valid[0] <= red_valid[RED_STEPS];
            r_x2_valid[1] <= r_x2_valid[0];
            r_f1_valid    <= cell_valid[CELLS];
            r_f2_valid    <= r_f1_valid;
            r_f3_valid    <= r_f2_valid;
            r_out_valid   <= r_f3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_in_mag <= n_mag;
        end
    end

    assign red_valid[0] = r_in_valid;
    assign red_value[0] = {4'd0, r_in_mag, 28'd0};

    for (genvar g = 0; g < RED_STEPS; g++) begin : g_reduce
        cts_mod_cell #(
            .MODULUS (TWO_PI_W << (RED_STEPS - 1 - g))
        ) u_mod_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_valid (red_valid[g]),
            .i_value (red_value[g]),
            .o_valid (red_valid[g + 1]),
            .o_value (red_value[g + 1])
        );
    end

    assign n_x = red_value[RED_STEPS] << X_SHIFT;

    cts_qmul u_square (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_a   (n_x),
        .i_b   (n_x),
        .o_p   (n_x2)
    );

    assign cell_valid[0] = r_x2_valid[1];
    assign cell_term[0]  = 64'd1 << cts_pkg::IFB;
    assign cell_sum[0]   = 64'd0;
    assign cell_x2[0]    = n_x2;

    for (genvar g = 0; g < CELLS; g++) begin : g_series
        cts_term_cell #(
            .TERM_INDEX (g + 1)
        ) u_term_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_valid (cell_valid[g]),
            .i_term  (cell_term[g]),
            .i_sum   (cell_sum[g]),
            .i_x2    (cell_x2[g]),
            .o_valid (cell_valid[g + 1]),
            .o_term  (cell_term[g + 1]),
            .o_sum   (cell_sum[g + 1]),
            .o_x2    (cell_x2[g + 1])
        );
    end

    assign n_f3_sum  = r_f2_mag + HALF;
    assign n_clamped = (r_f3_rnd > ONE_R) ? ONE_R : r_f3_rnd;
    assign n_wide    = r_f3_neg ? (64'd0 - 64'(n_clamped)) : 64'(n_clamped);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (LAST_SUB) begin
                r_f1_sum <= cell_sum[CELLS] - cell_term[CELLS];
            end else begin
                r_f1_sum <= cell_sum[CELLS] + cell_term[CELLS];
            end
            r_f2_neg <= r_f1_sum[63];
            r_f2_mag <= r_f1_sum[63] ? (64'd0 - r_f1_sum) : r_f1_sum;
            r_f3_neg <= r_f2_neg;
            r_f3_rnd <= n_f3_sum[63:RSH];
            r_cosine <= n_wide[31:0];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_cosine = r_cosine;

endmodule
